/* rtl/depth_pixel_backprojection_defines.svh */
// Assertion macros shared by the depth back-projection RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`ifndef ASSERT_OFF
`define DPB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define DPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPB_ASSERT(lbl, clk, rstn, prop, msg)
`define DPB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/dpb_pkg.sv */
// Shared types and constants for the depth pixel back-projection block.
// No dependencies.
package dpb_pkg;

    localparam int CFG_W     = 64;
    localparam int CFG_AW    = 3;
    localparam int Q_BITS    = 32;
    localparam int Q_FRAC    = 16;
    localparam int COLOR_W   = 24;
    localparam int COORD_FW  = 10;
    localparam int DEPTH_FW  = 11;
    localparam int PIX_TW    = ((2*COORD_FW + DEPTH_FW + COLOR_W + 7) / 8) * 8;
    localparam int OUT_TW    = 120;

    localparam logic signed [Q_BITS-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [Q_BITS-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_AW-1:0] {
        REG_ROW0_LO   = 3'd0,
        REG_ROW0_HI   = 3'd1,
        REG_ROW1_LO   = 3'd2,
        REG_ROW1_HI   = 3'd3,
        REG_ROW2_LO   = 3'd4,
        REG_ROW2_HI   = 3'd5,
        REG_DEPTH_MAP = 3'd6,
        REG_MIN_DEPTH = 3'd7
    } dpb_reg_t;

endpackage

/* rtl/depth_pixel_backprojection.sv */
// Depth pixel back-projection: one pixel in, at most one colored Q16.16 point out.
// One pixel is taken every clock while the output is not stalled; the 32 quotient
// stages of the divider make up most of the pipeline. A stall at the output freezes the
// whole pipeline; pixels that are too shallow or give a singular system leave no result.
// Uses dpb_pkg, dpb_smul, dpb_div and the defines header.
`include "depth_pixel_backprojection_defines.svh"
module depth_pixel_backprojection import dpb_pkg::*; #(
    parameter int DEPTH_BITS = 11,
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pixel_col, pixel_row, depth_raw, blue, green, red
    input  logic [PIX_TW-1:0]     s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // point_x, point_y, point_z, out_blue, out_green, out_red
    output logic [OUT_TW-1:0]     m_tdata
);
    localparam int CW   = COORD_BITS;
    localparam int DW   = DEPTH_BITS;
    localparam int CTK  = (CW < COORD_FW) ? CW : COORD_FW;
    localparam int DTK  = (DW < DEPTH_FW) ? DW : DEPTH_FW;
    localparam int ZFW  = DW + 34;
    localparam int PXW  = CW + 33;
    localparam int AW   = CW + 34;
    localparam int ZQW  = 2 * Q_BITS - Q_FRAC;
    localparam int ZQXW = ZQW + CW + 1;
    localparam int BW   = CW + 51;
    localparam int DTW  = 2 * AW + 1;
    localparam int NUMW = AW + BW + 1;
    localparam int NW   = NUMW + Q_FRAC;
    localparam int SW   = Q_BITS + COLOR_W;
    localparam int MD   = 4;
    localparam logic signed [ZFW-1:0] ZMAX = ZFW'(Q_MAX);
    localparam logic signed [ZFW-1:0] ZMIN = ZFW'(Q_MIN);

    logic [CFG_W-1:0]  prow_reg [0:5];
    logic [CFG_W-1:0]  dmap_reg;
    logic [Q_BITS-1:0] min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) prow_reg[i] <= '0;
            dmap_reg <= '0;
            min_reg  <= '0;
        end else if (cfg_we) begin
            case (dpb_reg_t'(cfg_addr))
                REG_ROW0_LO:   prow_reg[0] <= cfg_wdata;
                REG_ROW0_HI:   prow_reg[1] <= cfg_wdata;
                REG_ROW1_LO:   prow_reg[2] <= cfg_wdata;
                REG_ROW1_HI:   prow_reg[3] <= cfg_wdata;
                REG_ROW2_LO:   prow_reg[4] <= cfg_wdata;
                REG_ROW2_HI:   prow_reg[5] <= cfg_wdata;
                REG_DEPTH_MAP: dmap_reg    <= cfg_wdata;
                REG_MIN_DEPTH: min_reg     <= cfg_wdata[Q_BITS-1:0];
                default:       ;
            endcase
        end
    end

    logic signed [Q_BITS-1:0] p00, p01, p02, p03, p10, p11, p12, p13;
    logic signed [Q_BITS-1:0] p20, p21, p22, p23, scale, offs, zmin;
    assign p00   = $signed(prow_reg[0][31:0]);
    assign p01   = $signed(prow_reg[0][63:32]);
    assign p02   = $signed(prow_reg[1][31:0]);
    assign p03   = $signed(prow_reg[1][63:32]);
    assign p10   = $signed(prow_reg[2][31:0]);
    assign p11   = $signed(prow_reg[2][63:32]);
    assign p12   = $signed(prow_reg[3][31:0]);
    assign p13   = $signed(prow_reg[3][63:32]);
    assign p20   = $signed(prow_reg[4][31:0]);
    assign p21   = $signed(prow_reg[4][63:32]);
    assign p22   = $signed(prow_reg[5][31:0]);
    assign p23   = $signed(prow_reg[5][63:32]);
    assign scale = $signed(dmap_reg[31:0]);
    assign offs  = $signed(dmap_reg[63:32]);
    assign zmin  = $signed(min_reg);

    logic adv;
    logic m_tvalid_reg;
    logic [OUT_TW-1:0] m_tdata_reg;
    assign adv = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: input
    logic v1_reg;
    logic [CW-1:0] x1_reg, y1_reg;
    logic [DW-1:0] d1_reg;
    logic [COLOR_W-1:0] col1_reg;
    // stage 2: depth map, coordinate products
    logic v2_reg;
    logic [CW-1:0] x2_reg, y2_reg;
    logic [COLOR_W-1:0] col2_reg;
    logic signed [ZFW-1:0] zf2_reg;
    logic signed [PXW-1:0] p20x2_reg, p21x2_reg, p20y2_reg, p21y2_reg, p23x2_reg, p23y2_reg;
    // stage 3: Z saturate and depth gate, matrix A
    logic v3_reg;
    logic [CW-1:0] x3_reg, y3_reg;
    logic [COLOR_W-1:0] col3_reg;
    logic signed [Q_BITS-1:0] z3_reg;
    logic signed [AW-1:0] a00_3_reg, a01_3_reg, a10_3_reg, a11_3_reg;
    logic signed [PXW-1:0] p23x3_reg, p23y3_reg;
    logic signed [Q_BITS-1:0] zs_next;
    // stage 4: Z products
    logic v4_reg;
    logic [CW-1:0] x4_reg, y4_reg;
    logic [COLOR_W-1:0] col4_reg;
    logic signed [Q_BITS-1:0] z4_reg;
    logic signed [AW-1:0] a00_4_reg, a01_4_reg, a10_4_reg, a11_4_reg;
    logic signed [PXW-1:0] p23x4_reg, p23y4_reg;
    logic signed [2*Q_BITS-1:0] pz22_4_reg, pz02_4_reg, pz12_4_reg;
    // stage 5: scaled products and constant terms of b
    logic v5_reg;
    logic [COLOR_W-1:0] col5_reg;
    logic signed [Q_BITS-1:0] z5_reg;
    logic signed [AW-1:0] a00_5_reg, a01_5_reg, a10_5_reg, a11_5_reg;
    logic signed [ZQXW-1:0] zqx5_reg, zqy5_reg;
    logic signed [BW-1:0] c0_5_reg, c1_5_reg;
    logic signed [ZQW-1:0] zq_next;
    // stage 6: vector b
    logic v6_reg;
    logic [COLOR_W-1:0] col6_reg;
    logic signed [Q_BITS-1:0] z6_reg;
    logic signed [AW-1:0] a00_6_reg, a01_6_reg, a10_6_reg, a11_6_reg;
    logic signed [BW-1:0] b0_6_reg, b1_6_reg;

    always_comb begin
        if (zf2_reg > ZMAX) begin
            zs_next = Q_MAX;
        end else if (zf2_reg < ZMIN) begin
            zs_next = Q_MIN;
        end else begin
            zs_next = zf2_reg[Q_BITS-1:0];
        end
        zq_next = pz22_4_reg[2*Q_BITS-1:Q_FRAC];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && !(zs_next < zmin);
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
        if (adv) begin
            x1_reg   <= CW'(s_tdata[CTK-1:0]);
            y1_reg   <= CW'(s_tdata[COORD_FW +: CTK]);
            d1_reg   <= DW'(s_tdata[2*COORD_FW +: DTK]);
            col1_reg <= s_tdata[2*COORD_FW+DEPTH_FW +: COLOR_W];

            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            col2_reg  <= col1_reg;
            zf2_reg   <= ZFW'(scale) * ZFW'($signed({1'b0, d1_reg})) + ZFW'(offs);
            p20x2_reg <= PXW'(p20) * PXW'($signed({1'b0, x1_reg}));
            p21x2_reg <= PXW'(p21) * PXW'($signed({1'b0, x1_reg}));
            p20y2_reg <= PXW'(p20) * PXW'($signed({1'b0, y1_reg}));
            p21y2_reg <= PXW'(p21) * PXW'($signed({1'b0, y1_reg}));
            p23x2_reg <= PXW'(p23) * PXW'($signed({1'b0, x1_reg}));
            p23y2_reg <= PXW'(p23) * PXW'($signed({1'b0, y1_reg}));

            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            col3_reg  <= col2_reg;
            z3_reg    <= zs_next;
            a00_3_reg <= AW'(p00) - AW'(p20x2_reg);
            a01_3_reg <= AW'(p01) - AW'(p21x2_reg);
            a10_3_reg <= AW'(p10) - AW'(p20y2_reg);
            a11_3_reg <= AW'(p11) - AW'(p21y2_reg);
            p23x3_reg <= p23x2_reg;
            p23y3_reg <= p23y2_reg;

            x4_reg     <= x3_reg;
            y4_reg     <= y3_reg;
            col4_reg   <= col3_reg;
            z4_reg     <= z3_reg;
            a00_4_reg  <= a00_3_reg;
            a01_4_reg  <= a01_3_reg;
            a10_4_reg  <= a10_3_reg;
            a11_4_reg  <= a11_3_reg;
            p23x4_reg  <= p23x3_reg;
            p23y4_reg  <= p23y3_reg;
            pz22_4_reg <= (2*Q_BITS)'(p22) * (2*Q_BITS)'(z3_reg);
            pz02_4_reg <= (2*Q_BITS)'(p02) * (2*Q_BITS)'(z3_reg);
            pz12_4_reg <= (2*Q_BITS)'(p12) * (2*Q_BITS)'(z3_reg);

            col5_reg  <= col4_reg;
            z5_reg    <= z4_reg;
            a00_5_reg <= a00_4_reg;
            a01_5_reg <= a01_4_reg;
            a10_5_reg <= a10_4_reg;
            a11_5_reg <= a11_4_reg;
            zqx5_reg  <= ZQXW'(zq_next) * ZQXW'($signed({1'b0, x4_reg}));
            zqy5_reg  <= ZQXW'(zq_next) * ZQXW'($signed({1'b0, y4_reg}));
            c0_5_reg  <= BW'(p23x4_reg) - BW'($signed(pz02_4_reg[2*Q_BITS-1:Q_FRAC]))
                       - BW'(p03);
            c1_5_reg  <= BW'(p23y4_reg) - BW'($signed(pz12_4_reg[2*Q_BITS-1:Q_FRAC]))
                       - BW'(p13);

            col6_reg  <= col5_reg;
            z6_reg    <= z5_reg;
            a00_6_reg <= a00_5_reg;
            a01_6_reg <= a01_5_reg;
            a10_6_reg <= a10_5_reg;
            a11_6_reg <= a11_5_reg;
            b0_6_reg  <= BW'(zqx5_reg) + c0_5_reg;
            b1_6_reg  <= BW'(zqy5_reg) + c1_5_reg;
        end
    end

    // stages 7..10: cross products
    logic signed [2*AW-1:0]  m_a00a11, m_a01a10;
    logic signed [AW+BW-1:0] m_b0a11, m_a01b1, m_a00b1, m_b0a10;

    dpb_smul #(.AW(AW), .BW(AW)) u_mul_det0 (
        .aclk(aclk), .en(adv), .a(a00_6_reg), .b(a11_6_reg), .p(m_a00a11));
    dpb_smul #(.AW(AW), .BW(AW)) u_mul_det1 (
        .aclk(aclk), .en(adv), .a(a01_6_reg), .b(a10_6_reg), .p(m_a01a10));
    dpb_smul #(.AW(BW), .BW(AW)) u_mul_nx0 (
        .aclk(aclk), .en(adv), .a(b0_6_reg), .b(a11_6_reg), .p(m_b0a11));
    dpb_smul #(.AW(AW), .BW(BW)) u_mul_nx1 (
        .aclk(aclk), .en(adv), .a(a01_6_reg), .b(b1_6_reg), .p(m_a01b1));
    dpb_smul #(.AW(AW), .BW(BW)) u_mul_ny0 (
        .aclk(aclk), .en(adv), .a(a00_6_reg), .b(b1_6_reg), .p(m_a00b1));
    dpb_smul #(.AW(BW), .BW(AW)) u_mul_ny1 (
        .aclk(aclk), .en(adv), .a(b0_6_reg), .b(a10_6_reg), .p(m_b0a10));

    logic          sv_reg   [0:MD-1];
    logic [SW-1:0] spay_reg [0:MD-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MD; i++) sv_reg[i] <= 1'b0;
        end else if (adv) begin
            sv_reg[0] <= v6_reg;
            for (int i = 1; i < MD; i++) sv_reg[i] <= sv_reg[i-1];
        end
        if (adv) begin
            spay_reg[0] <= {col6_reg, z6_reg};
            for (int i = 1; i < MD; i++) spay_reg[i] <= spay_reg[i-1];
        end
    end

    // stage 11: determinant and numerators; stage 12: magnitudes for the divider
    logic v11_reg, v12_reg;
    logic [SW-1:0] pay11_reg, pay12_reg;
    logic signed [DTW-1:0]  det11_reg;
    logic signed [NUMW-1:0] nx11_reg, ny11_reg;
    logic [NW-1:0]  nmx12_reg, nmy12_reg;
    logic [DTW-1:0] dm12_reg;
    logic negx12_reg, negy12_reg;
    logic [NUMW-1:0] nmx_next, nmy_next;
    logic [DTW-1:0]  dm_next;

    always_comb begin
        nmx_next = nx11_reg[NUMW-1] ? (~nx11_reg + 1'b1) : nx11_reg;
        nmy_next = ny11_reg[NUMW-1] ? (~ny11_reg + 1'b1) : ny11_reg;
        dm_next  = det11_reg[DTW-1] ? (~det11_reg + 1'b1) : det11_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
        end else if (adv) begin
            v11_reg <= sv_reg[MD-1];
            v12_reg <= v11_reg && (det11_reg != '0);
        end
        if (adv) begin
            pay11_reg  <= spay_reg[MD-1];
            det11_reg  <= DTW'(m_a00a11) - DTW'(m_a01a10);
            nx11_reg   <= NUMW'(m_b0a11) - NUMW'(m_a01b1);
            ny11_reg   <= NUMW'(m_a00b1) - NUMW'(m_b0a10);
            pay12_reg  <= pay11_reg;
            nmx12_reg  <= NW'(nmx_next) << Q_FRAC;
            nmy12_reg  <= NW'(nmy_next) << Q_FRAC;
            dm12_reg   <= dm_next;
            negx12_reg <= nx11_reg[NUMW-1] ^ det11_reg[DTW-1];
            negy12_reg <= ny11_reg[NUMW-1] ^ det11_reg[DTW-1];
        end
    end

    logic div_valid;
    logic signed [Q_BITS-1:0] div_x, div_y;
    logic [SW-1:0] div_pay;

    dpb_div #(.NW(NW), .DW(DTW), .PW(SW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (v12_reg),
        .in_nx    (nmx12_reg),
        .in_ny    (nmy12_reg),
        .in_d     (dm12_reg),
        .in_negx  (negx12_reg),
        .in_negy  (negy12_reg),
        .in_pay   (pay12_reg),
        .out_valid(div_valid),
        .out_x    (div_x),
        .out_y    (div_y),
        .out_pay  (div_pay)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= div_valid;
        end
        if (adv) begin
            m_tdata_reg <= {div_pay[SW-1:Q_BITS], div_pay[Q_BITS-1:0], div_y, div_x};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `DPB_ASSERT_ALWAYS(a_rst_clears, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `DPB_ASSERT(a_rise_from_div, aclk, aresetn, $rose(m_tvalid) |-> $past(div_valid), "output item without divider result")
    `DPB_ASSERT(a_stall_back, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
endmodule

/* rtl/dpb_smul.sv */
// Pipelined signed multiplier, four register stages, 32x32 partial products.
// No dependencies; operands up to 64 bits each.
module dpb_smul #(
    parameter int AW = 47,
    parameter int BW = 47
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [AW-1:0]        a,
    input  logic signed [BW-1:0]        b,
    output logic signed [AW+BW-1:0]     p
);
    localparam int PW = AW + BW;

    logic [63:0]         am_reg, bm_reg;
    logic                neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]         pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0]        sum_reg;
    logic signed [PW-1:0] p_reg;
    logic [AW-1:0]       am_next;
    logic [BW-1:0]       bm_next;
    logic [127:0]        sum_next;

    always_comb begin
        am_next  = a[AW-1] ? (~a + 1'b1) : a;
        bm_next  = b[BW-1] ? (~b + 1'b1) : b;
        sum_next = {64'd0, pp00_reg} + ({64'd0, pp01_reg} << 32)
                 + ({64'd0, pp10_reg} << 32) + {pp11_reg, 64'd0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            am_reg   <= 64'(am_next);
            bm_reg   <= 64'(bm_next);
            neg1_reg <= a[AW-1] ^ b[BW-1];
            pp00_reg <= am_reg[31:0]  * bm_reg[31:0];
            pp01_reg <= am_reg[31:0]  * bm_reg[63:32];
            pp10_reg <= am_reg[63:32] * bm_reg[31:0];
            pp11_reg <= am_reg[63:32] * bm_reg[63:32];
            neg2_reg <= neg1_reg;
            sum_reg  <= sum_next;
            neg3_reg <= neg2_reg;
            p_reg    <= neg3_reg ? $signed(~sum_reg[PW-1:0] + 1'b1) : $signed(sum_reg[PW-1:0]);
        end
    end

    assign p = p_reg;
endmodule

/* rtl/dpb_div.sv */
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit
// per stage, with signed saturation to Q16.16. Uses dpb_pkg and the defines header.
`include "depth_pixel_backprojection_defines.svh"
module dpb_div import dpb_pkg::*; #(
    parameter int NW = 122,
    parameter int DW = 89,
    parameter int PW = 56
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [NW-1:0]            in_nx,
    input  logic [NW-1:0]            in_ny,
    input  logic [DW-1:0]            in_d,
    input  logic                     in_negx,
    input  logic                     in_negy,
    input  logic [PW-1:0]            in_pay,
    output logic                     out_valid,
    output logic signed [Q_BITS-1:0] out_x,
    output logic signed [Q_BITS-1:0] out_y,
    output logic [PW-1:0]            out_pay
);
    localparam int ST = Q_BITS;

    logic              v_reg    [0:ST];
    logic [NW-1:0]     rx_reg   [0:ST];
    logic [NW-1:0]     ry_reg   [0:ST];
    logic [Q_BITS-1:0] qx_reg   [0:ST];
    logic [Q_BITS-1:0] qy_reg   [0:ST];
    logic [DW-1:0]     d_reg    [0:ST];
    logic              ovfx_reg [0:ST];
    logic              ovfy_reg [0:ST];
    logic              negx_reg [0:ST];
    logic              negy_reg [0:ST];
    logic [PW-1:0]     pay_reg  [0:ST];
    logic [NW-1:0]     dtop;

    assign dtop = NW'(in_d) << ST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            rx_reg[0]   <= in_nx;
            ry_reg[0]   <= in_ny;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            d_reg[0]    <= in_d;
            ovfx_reg[0] <= in_nx >= dtop;
            ovfy_reg[0] <= in_ny >= dtop;
            negx_reg[0] <= in_negx;
            negy_reg[0] <= in_negy;
            pay_reg[0]  <= in_pay;
        end
    end

    for (genvar k = 0; k < ST; k++) begin : g_stage
        localparam int SH = ST - 1 - k;
        logic [NW-1:0] trial;
        logic          gex, gey;

        always_comb begin
            trial = NW'(d_reg[k]) << SH;
            gex   = rx_reg[k] >= trial;
            gey   = ry_reg[k] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
            if (en) begin
                rx_reg[k+1]   <= gex ? rx_reg[k] - trial : rx_reg[k];
                ry_reg[k+1]   <= gey ? ry_reg[k] - trial : ry_reg[k];
                qx_reg[k+1]   <= qx_reg[k] | (Q_BITS'(gex) << SH);
                qy_reg[k+1]   <= qy_reg[k] | (Q_BITS'(gey) << SH);
                d_reg[k+1]    <= d_reg[k];
                ovfx_reg[k+1] <= ovfx_reg[k];
                ovfy_reg[k+1] <= ovfy_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                pay_reg[k+1]  <= pay_reg[k];
            end
        end
    end

    always_comb begin
        if (negx_reg[ST]) begin
            out_x = (ovfx_reg[ST] || qx_reg[ST] > Q_BITS'(Q_MIN)) ? Q_MIN
                  : $signed(~qx_reg[ST] + 1'b1);
        end else begin
            out_x = (ovfx_reg[ST] || qx_reg[ST][Q_BITS-1]) ? Q_MAX : $signed(qx_reg[ST]);
        end
        if (negy_reg[ST]) begin
            out_y = (ovfy_reg[ST] || qy_reg[ST] > Q_BITS'(Q_MIN)) ? Q_MIN
                  : $signed(~qy_reg[ST] + 1'b1);
        end else begin
            out_y = (ovfy_reg[ST] || qy_reg[ST][Q_BITS-1]) ? Q_MAX : $signed(qy_reg[ST]);
        end
    end

    assign out_valid = v_reg[ST];
    assign out_pay   = pay_reg[ST];

    `DPB_ASSERT(a_rem_below_div, aclk, aresetn, v_reg[ST] && !ovfx_reg[ST] |-> rx_reg[ST] < NW'(d_reg[ST]), "final remainder not below divisor")
    `DPB_ASSERT(a_first_rem, aclk, aresetn, v_reg[1] && !ovfy_reg[1] |-> ry_reg[1] < (NW'(d_reg[1]) << (ST - 1)), "first stage remainder too large")
    `DPB_ASSERT(a_hold, aclk, aresetn, !en |=> $stable(out_valid) && $stable(out_x), "divider moved while stalled")
endmodule
